FILE: rtl/vwsd_pkg.sv
// Package for the video word stream deframer: payload structs, register
// indexes, reset values and the bit positions of the capture word.
// No dependencies.
`default_nettype none
package vwsd_pkg;

  // Default width of the stored line number.
  localparam int unsigned LINE_BITS_DEFAULT = 12;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 12;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_SHIFT_LINE    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXEMPT_START_LINE = 2'd3;

  // Register reset values.
  localparam logic [11:0] ACTIVE_WIDTH_RESET      = 12'd324;
  localparam logic [11:0] ACTIVE_HEIGHT_RESET     = 12'd257;
  localparam logic [11:0] ROW_SHIFT_LINE_RESET    = 12'd20;
  localparam logic [11:0] EXEMPT_START_LINE_RESET = 12'h013;

  // Capture word layout.
  localparam int unsigned COUNT_LSB       = 24;
  localparam int unsigned COUNT_MSB       = 30;
  localparam int unsigned SYNC_BIT        = 16;
  localparam int unsigned FRAME_START_BIT = 15;
  localparam int unsigned BLANK_BIT       = 9;

  // Column counter width and the value at which it stops.
  localparam int unsigned COL_BITS  = 13;
  localparam logic [COL_BITS-1:0] COL_LIMIT = 13'd4096;

  typedef struct packed {
    logic [11:0] active_width;
    logic [11:0] active_height;
    logic [11:0] row_shift_line;
    logic [11:0] exempt_start_line;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_transfer;
  } in_item_t;

  typedef struct packed {
    logic        pixel_write;
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
    logic [15:0] pixel_value;
    logic        frame_done;
    logic        sequence_error;
    logic [6:0]  received_count;
    logic [6:0]  expected_count;
    logic        transfer_end;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/vwsd_cfg_regs.sv
// Configuration register file of the deframer.
// Depends on vwsd_pkg.
`default_nettype none
module vwsd_cfg_regs
  import vwsd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register writes, one register per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_width      <= ACTIVE_WIDTH_RESET;
      cfg.active_height     <= ACTIVE_HEIGHT_RESET;
      cfg.row_shift_line    <= ROW_SHIFT_LINE_RESET;
      cfg.exempt_start_line <= EXEMPT_START_LINE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:      cfg.active_width      <= cfg_data;
        REG_ACTIVE_HEIGHT:     cfg.active_height     <= cfg_data;
        REG_ROW_SHIFT_LINE:    cfg.row_shift_line    <= cfg_data;
        REG_EXEMPT_START_LINE: cfg.exempt_start_line <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vwsd_core.sv
// Input register, deframing state and the per-word decode logic.
// Depends on vwsd_pkg.
`default_nettype none
module vwsd_core
  import vwsd_pkg::*;
#(
  parameter int unsigned LINE_BITS = LINE_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  wire logic res_ready,
  output out_item_t res_data
);

  // Compare width: wide enough for both the line field and the registers.
  localparam int unsigned CMP_BITS = (LINE_BITS > 12) ? LINE_BITS : 12;

  logic                 held;
  in_item_t             item;
  logic                 advance;

  logic [6:0]           next_count;
  logic                 in_blanking;
  logic [COL_BITS-1:0]  column_counter;
  logic [LINE_BITS-1:0] line_number;

  logic [6:0]           received;
  logic                 sync;
  logic                 blank_next;
  logic [LINE_BITS-1:0] line_next;
  logic [COL_BITS-1:0]  col_cur;
  logic [COL_BITS-1:0]  column_counter_next;
  logic [CMP_BITS-1:0]  line_ext;
  logic [CMP_BITS-1:0]  prev_line_ext;
  logic [CMP_BITS-1:0]  row_full;
  logic [COL_BITS-1:0]  col_minus;
  logic                 write;

  // Input register: loaded when empty or when the held transaction moves on.
  assign in_ready  = !held || res_ready;
  assign advance   = held && res_ready;
  assign res_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  // Decode of the held word against the current state.
  always_comb begin
    received      = item.data_word[COUNT_MSB:COUNT_LSB];
    sync          = item.data_word[SYNC_BIT];
    blank_next    = sync ? item.data_word[BLANK_BIT] : in_blanking;
    line_next     = sync ? item.data_word[LINE_BITS-1:0] : line_number;
    col_cur       = sync ? '0 : column_counter;
    line_ext      = CMP_BITS'(line_next);
    prev_line_ext = CMP_BITS'(line_number);

    write = !blank_next && (col_cur != '0)
         && (col_cur <= COL_BITS'(cfg.active_width))
         && (line_ext != '0)
         && (line_ext <= CMP_BITS'(cfg.active_height));

    if (line_ext > CMP_BITS'(cfg.row_shift_line)) begin
      row_full = line_ext - CMP_BITS'(2);
    end else begin
      row_full = line_ext - CMP_BITS'(1);
    end
    col_minus = col_cur - COL_BITS'(1);

    if (!blank_next && (col_cur < COL_LIMIT)) begin
      column_counter_next = col_cur + COL_BITS'(1);
    end else begin
      column_counter_next = col_cur;
    end

    res_data.pixel_write    = write;
    res_data.pixel_row      = write ? row_full[11:0] : 12'd0;
    res_data.pixel_column   = write ? col_minus[11:0] : 12'd0;
    res_data.pixel_value    = write ? item.data_word[15:0] : 16'd0;
    res_data.frame_done     = sync && item.data_word[FRAME_START_BIT]
                           && (prev_line_ext != CMP_BITS'(cfg.exempt_start_line));
    res_data.sequence_error = (received != next_count);
    res_data.received_count = received;
    res_data.expected_count = next_count;
    res_data.transfer_end   = item.end_of_transfer;
  end

  // Deframing state advances once per transaction passed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_count     <= '0;
      in_blanking    <= 1'b0;
      column_counter <= '0;
      line_number    <= '0;
    end else if (advance) begin
      next_count     <= received + 7'd1;
      in_blanking    <= blank_next;
      column_counter <= column_counter_next;
      line_number    <= line_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vwsd_out_reg.sv
// Result register between the decode logic and the output channel.
// Depends on vwsd_pkg.
`default_nettype none
module vwsd_out_reg
  import vwsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_valid,
  output logic      res_ready,
  input  out_item_t res_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  // Takes a new result when empty or when the held one leaves this cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/video_word_stream_deframer.sv
// Top level of the video word stream deframer.
// Depends on vwsd_pkg, vwsd_cfg_regs, vwsd_core and vwsd_out_reg.
//
//   Channel   Signals                                    Direction
//   in        in_valid, in_ready, in_data (in_item_t)    into the block
//   out       out_valid, out_ready, out_data (out_item_t) out of the block
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  into the block
//
// Each word passes from input to output through the input register, where it
// is decoded against the line and column state, and then the result register.
// One word per cycle holds with no output stall; the state update is a single
// compare and increment path. A stall on the output holds both registers, and
// the input accepts again as soon as the result register frees up.
// Reset (rst, synchronous) clears state and valid flags; data is not reset.
`default_nettype none
module video_word_stream_deframer
  import vwsd_pkg::*;
#(
  parameter int unsigned LINE_BITS = LINE_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  in_item_t                       in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output out_item_t                      out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;

  // Configuration registers.
  vwsd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Decode and state.
  vwsd_core #(
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Result register.
  vwsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
